>>> rtl/rfpmr_pkg.sv
// ----------------------------------------------------------------------------
// rfpmr_pkg
// Types and constants shared by the RF pulse message receiver.
// ----------------------------------------------------------------------------
package rfpmr_pkg;

   localparam logic [1:0] KIND_EDGE    = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;

   localparam logic [1:0] REG_MIN_PERIOD  = 2'd0;
   localparam logic [1:0] REG_MAX_PULSES  = 2'd1;
   localparam logic [1:0] REG_MIN_MESSAGE = 2'd2;

   localparam logic [15:0] MIN_PERIOD_RESET  = 16'd30;
   localparam logic [7:0]  MAX_PULSES_RESET  = 8'd20;
   localparam logic [7:0]  MIN_MESSAGE_RESET = 8'd16;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] timestamp;
      logic        line_level;
   } req_type;

   typedef struct packed {
      logic        has_data;
      logic [31:0] word;
      logic        word_valid;
      logic        last_word;
      logic [15:0] pulse_duration;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_DIV,
      ST_EDGE_STORE,
      ST_EDGE_AVG_MUL,
      ST_EDGE_AVG_DIV,
      ST_READ_HDR,
      ST_READ_VAL,
      ST_READ_MUL,
      ST_REL_RD,
      ST_REL_CHK,
      ST_DONE
   } state_type;

endpackage

>>> rtl/rf_pulse_message_receiver.sv
// ----------------------------------------------------------------------------
// rf_pulse_message_receiver
// An edge runs one 16-step serial divide, and a second when the period
// estimate is refined; reads pass READ_HDR, READ_VAL and READ_MUL, releases
// walk ring words in REL_RD and REL_CHK. One item at a time; a shared
// restoring divider yields one bit per cycle. Synchronous reset clears
// control state; ring contents are undefined until written.
// ----------------------------------------------------------------------------
module rf_pulse_message_receiver
   import rfpmr_pkg::*;
#(
   parameter int RING_DEPTH = 256,
   parameter int TIME_WIDTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int TW = TIME_WIDTH;
   localparam int CW = $clog2(TW + 1);

   state_type state_ff, state_in;

   logic [15:0]   min_period_ff;
   logic [7:0]    max_pulses_ff, min_message_ff;
   logic [TW-1:0] last_edge_ff, period_ff;
   logic [7:0]    frame_ff;
   logic [AW-1:0] wp_ff, rp_ff, cursor_ff;
   logic          finished_ff;

   logic [TW-1:0] ring [RING_DEPTH];
   logic [TW-1:0] rdata_ff;
   logic [AW-1:0] raddr;
   logic          rd_en;

   req_type       req_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   // shared divider
   logic [TW-1:0] quo_ff, rem_ff, den_ff, dividend_ff;
   logic [CW-1:0] cnt_ff;
   logic [TW:0]   trial;
   logic [TW-1:0] pulse_ff, periods_ff, hdr_ff;
   logic [7:0]    fc_ff;
   logic          commit_ff;

   logic          accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[3:2])
         REG_MIN_PERIOD:  csr_prdata = {16'd0, min_period_ff};
         REG_MAX_PULSES:  csr_prdata = {24'd0, max_pulses_ff};
         REG_MIN_MESSAGE: csr_prdata = {24'd0, min_message_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff  <= MIN_PERIOD_RESET;
         max_pulses_ff  <= MAX_PULSES_RESET;
         min_message_ff <= MIN_MESSAGE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            REG_MIN_PERIOD:  min_period_ff  <= csr_pwdata[15:0];
            REG_MAX_PULSES:  max_pulses_ff  <= csr_pwdata[7:0];
            REG_MIN_MESSAGE: min_message_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // derived edge values
   logic [AW-1:0] store_idx;
   logic [7:0]    fc_a, fc_b;
   logic          zero_clr;
   logic          is_long;
   assign zero_clr  = (periods_ff == '0);
   assign fc_a      = zero_clr ? 8'd0 : frame_ff;
   assign store_idx = wp_ff + AW'(fc_a);
   assign is_long   = periods_ff > TW'(max_pulses_ff);
   logic          store_hit;
   assign store_hit = (fc_a != 0) && (store_idx == rp_ff);
   assign fc_b      = (fc_a == 0) ? 8'd0 : (store_hit ? 8'd0 : fc_a + 8'd1);

   logic [AW-1:0] rd_idx;
   assign rd_idx = rp_ff + cursor_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  KIND_EDGE:    state_in = ST_EDGE_DIV;
                  KIND_READ:    state_in = (wp_ff == rp_ff || finished_ff ||
                                            rd_idx == wp_ff) ? ST_DONE : ST_READ_HDR;
                  KIND_RELEASE: state_in = (rp_ff == wp_ff) ? ST_DONE : ST_REL_RD;
                  default:      state_in = ST_DONE;
               endcase
            end
         end
         ST_EDGE_DIV:     if (cnt_ff == '0) state_in = ST_EDGE_STORE;
         ST_EDGE_STORE:   state_in = (!req_ff.line_level && fc_b != 0 && !is_long &&
                                      periods_ff == TW'(1)) ? ST_EDGE_AVG_MUL : ST_DONE;
         ST_EDGE_AVG_MUL: state_in = ST_EDGE_AVG_DIV;
         ST_EDGE_AVG_DIV: if (cnt_ff == '0) state_in = ST_DONE;
         ST_READ_HDR:     state_in = ST_READ_VAL;
         ST_READ_VAL:     state_in = ST_READ_MUL;
         ST_READ_MUL:     state_in = ST_DONE;
         ST_REL_RD:       state_in = (rp_ff == wp_ff) ? ST_DONE : ST_REL_CHK;
         ST_REL_CHK:      state_in = (rdata_ff > TW'(max_pulses_ff)) ? ST_DONE : ST_REL_RD;
         ST_DONE:         state_in = ST_IDLE;
         default:         state_in = ST_IDLE;
      endcase
   end

   // memory read address
   always_comb begin
      rd_en = 1'b0;
      raddr = rp_ff;
      case (state_ff)
         ST_IDLE:    begin rd_en = accept; raddr = rp_ff; end
         ST_READ_HDR: begin rd_en = 1'b1; raddr = rp_ff + cursor_ff; end
         ST_REL_RD:  begin rd_en = 1'b1; raddr = rp_ff; end
         default:    ;
      endcase
   end

   assign trial = {rem_ff, quo_ff[TW-1]} - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= ring[raddr];
      if (state_ff == ST_EDGE_STORE && fc_a != 0 && !store_hit)
         ring[store_idx] <= periods_ff;
      // write the frame header once the counts are in
      else if (state_ff == ST_DONE && commit_ff)
         ring[wp_ff - AW'(fc_ff)] <= period_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_edge_ff <= '0;
         period_ff    <= '0;
         frame_ff     <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cursor_ff    <= AW'(1);
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         commit_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_ff <= req_data;
                  rsp_ff <= '0;
                  if (req_data.kind == KIND_EDGE) begin
                     pulse_ff     <= TW'(req_data.timestamp) - last_edge_ff;
                     last_edge_ff <= TW'(req_data.timestamp);
                     quo_ff <= TW'(req_data.timestamp) - last_edge_ff
                               + (period_ff >> 1);
                     rem_ff <= '0;
                     den_ff <= period_ff;
                     cnt_ff <= CW'(TW);
                  end else if (req_data.kind == KIND_READ && wp_ff != rp_ff &&
                               !finished_ff && rd_idx == wp_ff) begin
                     finished_ff <= 1'b1;
                  end else if (req_data.kind == KIND_RELEASE) begin
                     cursor_ff   <= AW'(1);
                     finished_ff <= 1'b0;
                     if (rp_ff != wp_ff) rp_ff <= rp_ff + AW'(1);
                  end
               end
            end
            ST_EDGE_DIV, ST_EDGE_AVG_DIV: begin
               if (cnt_ff != '0) begin
                  cnt_ff <= cnt_ff - CW'(1);
                  if (!trial[TW]) begin
                     rem_ff <= trial[TW-1:0];
                     quo_ff <= {quo_ff[TW-2:0], 1'b1};
                  end else begin
                     rem_ff <= {rem_ff[TW-2:0], quo_ff[TW-1]};
                     quo_ff <= {quo_ff[TW-2:0], 1'b0};
                  end
               end else if (state_ff == ST_EDGE_DIV) begin
                  periods_ff <= (den_ff == '0) ? '1 : quo_ff;
               end else begin
                  period_ff <= quo_ff;
               end
            end
            ST_EDGE_STORE: begin
               rsp_ff.pulse_duration <= 16'(pulse_ff);
               frame_ff  <= fc_b;
               fc_ff     <= fc_b;
               commit_ff <= req_ff.line_level && period_ff > TW'(min_period_ff) &&
                            is_long && fc_b > min_message_ff;
               if (req_ff.line_level) begin
                  if (period_ff > TW'(min_period_ff) && is_long) begin
                     if (fc_b > min_message_ff) wp_ff <= wp_ff + AW'(fc_b);
                     frame_ff <= 8'd1;
                  end
               end else if (is_long || fc_b == 0) begin
                  frame_ff  <= 8'd0;
                  period_ff <= pulse_ff;
               end
            end
            ST_EDGE_AVG_MUL: begin
               quo_ff <= TW'(period_ff * fc_ff) + (pulse_ff << 1);
               rem_ff <= '0;
               den_ff <= TW'(fc_ff) + TW'(2);
               cnt_ff <= CW'(TW);
            end
            ST_READ_HDR: hdr_ff <= rdata_ff;
            ST_READ_VAL: ;
            ST_READ_MUL: begin
               rsp_ff.word       <= 32'(hdr_ff) * 32'(rdata_ff);
               rsp_ff.word_valid <= 1'b1;
               rsp_ff.last_word  <= (rdata_ff > TW'(max_pulses_ff)) ||
                                    (rd_idx + AW'(1) == wp_ff);
               cursor_ff <= cursor_ff + AW'(1);
               if ((rdata_ff > TW'(max_pulses_ff)) || (rd_idx + AW'(1) == wp_ff))
                  finished_ff <= 1'b1;
            end
            ST_REL_RD: ;
            ST_REL_CHK: begin
               rp_ff <= rp_ff + AW'(1);
            end
            ST_DONE: begin
               rsp_ff.has_data <= (wp_ff != rp_ff);
               rsp_valid_ff    <= 1'b1;
               commit_ff       <= 1'b0;
            end
            default: ;
         endcase
      end
   end

endmodule

>>> dv/rf_pulse_message_receiver_test.sv
// ----------------------------------------------------------------------------
// rf_pulse_message_receiver_test
// Self-checking bench for the RF pulse message receiver. Framed pulse trains
// with random timing are sent with reads and releases, under several register
// settings. A predictor computes each result word, which is then compared
// field by field with the word the block returns.
// ----------------------------------------------------------------------------
module rf_pulse_message_receiver_test
   import rfpmr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int ITEM_TARGET = 1550;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rf_pulse_message_receiver i_dut (.*);

   always #5 clock = ~clock;

   req_type pending_words[$];
   rsp_type expected_words[$];
   int      errors = 0;
   int      cycles = 0;
   int      items_sent = 0;
   int      words_read = 0;
   int      commits = 0;
   bit      steady = 1'b0;
   logic [15:0] stamp_now = '0;

   // predictor state
   logic [15:0] min_period;
   logic [7:0]  max_pulses;
   logic [7:0]  min_message;
   logic [15:0] last_edge;
   logic [15:0] period_est;
   logic [7:0]  frame_cnt;
   logic [7:0]  wr_ptr;
   logic [7:0]  rd_ptr;
   logic [7:0]  rd_cur;
   logic        rd_done;
   logic [15:0] ring[256];

   function automatic logic [15:0] edge_pulse(logic [15:0] now, logic low);
      logic [15:0] pulse;
      logic [15:0] periods;
      logic [15:0] rounded;
      logic [7:0]  idx;
      logic [31:0] num;
      pulse = now - last_edge;
      rounded = pulse + (period_est >> 1);
      periods = (period_est == 0) ? 16'hFFFF : rounded / period_est;
      last_edge = now;
      if (periods == 0) frame_cnt = 0;
      if (frame_cnt > 0) begin
         idx = wr_ptr + frame_cnt;
         frame_cnt = frame_cnt + 8'd1;
         if (idx == rd_ptr) frame_cnt = 0;
         else ring[idx] = periods;
      end
      if (low) begin
         if (period_est > min_period && periods > max_pulses) begin
            if (frame_cnt > min_message) begin
               ring[wr_ptr] = period_est;
               wr_ptr = wr_ptr + frame_cnt;
               commits++;
            end
            frame_cnt = 1;
         end
      end else begin
         if (periods > max_pulses) frame_cnt = 0;
         if (frame_cnt > 0) begin
            if (periods == 1) begin
               num = (32'(period_est) * frame_cnt + 2 * 32'(pulse)) & 32'hFFFF;
               period_est = 16'(num / (32'(frame_cnt) + 2));
            end
         end else begin
            period_est = pulse;
         end
      end
      return pulse;
   endfunction

   function automatic void next_word(ref rsp_type r);
      logic [7:0]  idx;
      logic [15:0] v;
      logic        last;
      if (wr_ptr == rd_ptr || rd_done) return;
      idx = rd_ptr + rd_cur;
      if (idx == wr_ptr) begin
         rd_done = 1'b1;
         return;
      end
      v = ring[idx];
      last = (v > max_pulses) || (8'(idx + 1) == wr_ptr);
      rd_cur = rd_cur + 8'd1;
      if (last) rd_done = 1'b1;
      r.word = 32'(ring[rd_ptr]) * 32'(v);
      r.word_valid = 1'b1;
      r.last_word = last;
      words_read++;
   endfunction

   function automatic void skip_message();
      if (rd_ptr != wr_ptr) begin
         rd_ptr = rd_ptr + 8'd1;
         while (rd_ptr != wr_ptr && ring[rd_ptr] <= max_pulses) rd_ptr = rd_ptr + 8'd1;
         if (rd_ptr != wr_ptr) rd_ptr = rd_ptr + 8'd1;
      end
      rd_cur = 1;
      rd_done = 1'b0;
   endfunction

   function automatic rsp_type receiver_step(req_type q);
      rsp_type r;
      r = '0;
      case (q.kind)
         KIND_EDGE:    r.pulse_duration = edge_pulse(q.timestamp, q.line_level);
         KIND_READ:    next_word(r);
         KIND_RELEASE: skip_message();
         default: ;
      endcase
      r.has_data = (wr_ptr != rd_ptr);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
      errors++;
   endtask

   // driver: advance on acceptance, hold while stalled
   bit req_taken = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
         end else if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 32)) begin
            req_valid <= 1'b1;
            req_data <= pending_words.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
         rsp_stall <= !steady && ($urandom_range(99) < 32);
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      cycles++;
      req_taken = req_valid && !req_stall && !reset;
      if (req_taken) begin
         expected_words.push_back(receiver_step(req_data));
         items_sent++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_data;
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", got.word, 32'd0);
         end else begin
            want = expected_words.pop_front();
            if (got.has_data !== want.has_data)
               report_mismatch("has_data", 32'(got.has_data), 32'(want.has_data));
            if (got.word !== want.word) report_mismatch("word", got.word, want.word);
            if (got.word_valid !== want.word_valid)
               report_mismatch("word_valid", 32'(got.word_valid), 32'(want.word_valid));
            if (got.last_word !== want.last_word)
               report_mismatch("last_word", 32'(got.last_word), 32'(want.last_word));
            if (got.pulse_duration !== want.pulse_duration)
               report_mismatch("pulse_duration", 32'(got.pulse_duration),
                               32'(want.pulse_duration));
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d words outstanding", expected_words.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic push_item(logic [1:0] kind, logic [15:0] ts, logic lvl);
      req_type q;
      q.kind = kind;
      q.timestamp = ts;
      q.line_level = lvl;
      pending_words.push_back(q);
   endtask

   task automatic push_edge(int dt, logic lvl);
      stamp_now = stamp_now + 16'(dt);
      push_item(KIND_EDGE, stamp_now, lvl);
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || expected_words.size() > 0 || req_valid)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 4'(idx) << 2;
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_MIN_PERIOD:  min_period = val[15:0];
         REG_MAX_PULSES:  max_pulses = val[7:0];
         default:         min_message = val[7:0];
      endcase
   endtask

   // one framed pulse train: estimate pulse, sync, data, closing sync
   task automatic push_message();
      int p;
      int n;
      int k;
      int jit;
      p = $urandom_range(120, 31);
      if (min_period >= 16'd120) p = $urandom_range(1000, 200);
      k = int'(max_pulses) + 1 + $urandom_range(4);
      while (k * p > 60000) p = p / 2 + 1;
      push_edge(p, 1'b0);
      push_edge(k * p + $urandom_range(p / 4), 1'b1);
      n = int'(min_message) + $urandom_range(12);
      if (n > 180) n = $urandom_range(180, 150);
      for (int i = 0; i < n; i++) begin
         jit = $urandom_range(p / 4);
         if ($urandom_range(1)) jit = -jit;
         push_edge(($urandom_range(3) == 0 ? 1 : $urandom_range(max_pulses < 3 ?
                    max_pulses : 3, 1)) * p + jit, 1'(i & 1));
      end
      push_edge(k * p + $urandom_range(p / 4), 1'b1);
      for (int i = $urandom_range(n + 4); i > 0; i--) push_item(KIND_READ, '0, 1'b0);
      if ($urandom_range(9) < 8) push_item(KIND_RELEASE, 16'($urandom), 1'($urandom));
   endtask

   task automatic push_noise();
      push_item(2'($urandom_range(3)), 16'($urandom), 1'($urandom));
   endtask

   task automatic random_phase(int count);
      int target;
      target = pending_words.size() + count;
      while (pending_words.size() < target) begin
         if ($urandom_range(9) == 0) push_noise();
         else push_message();
      end
   endtask

   initial begin
      min_period = MIN_PERIOD_RESET;
      max_pulses = MAX_PULSES_RESET;
      min_message = MIN_MESSAGE_RESET;
      last_edge = '0;
      period_est = '0;
      frame_cnt = '0;
      wr_ptr = '0;
      rd_ptr = '0;
      rd_cur = 8'd1;
      rd_done = 1'b0;
      foreach (ring[i]) ring[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero period, timestamp extremes, empty reads, unused kind
      push_item(KIND_READ, 16'hFFFF, 1'b1);
      push_item(KIND_RELEASE, 16'h0000, 1'b0);
      push_item(2'd3, 16'hFFFF, 1'b1);
      push_item(KIND_EDGE, 16'hFFFF, 1'b0);
      push_item(KIND_EDGE, 16'h0000, 1'b1);
      push_item(KIND_EDGE, 16'h0000, 1'b0);
      stamp_now = 16'hFF00;
      push_message();
      drain();

      csr_write(REG_MIN_PERIOD, 32'd0);
      csr_write(REG_MAX_PULSES, 32'd255);
      csr_write(REG_MIN_MESSAGE, 32'd1);
      random_phase(200);
      drain();

      csr_write(REG_MIN_PERIOD, 32'd65535);
      csr_write(REG_MAX_PULSES, 32'd1);
      csr_write(REG_MIN_MESSAGE, 32'd255);
      random_phase(150);
      drain();

      csr_write(REG_MIN_PERIOD, 32'd30);
      csr_write(REG_MAX_PULSES, 32'd20);
      csr_write(REG_MIN_MESSAGE, 32'd16);
      steady = 1'b1;
      random_phase(300);
      drain();
      steady = 1'b0;

      while (items_sent < ITEM_TARGET) begin
         csr_write(REG_MIN_PERIOD, $urandom_range(60));
         csr_write(REG_MAX_PULSES, $urandom_range(40, 2));
         csr_write(REG_MIN_MESSAGE, $urandom_range(30, 1));
         random_phase(200);
         drain();
      end

      $display("%0d items, %0d frames committed, %0d message words read back",
               items_sent, commits, words_read);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
